/* design/kvls_pkg.sv */
// Shared types and constants for the keyframe vector lerp sampler.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package kvls_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KEY_AW    = $clog2(MAX_KEYS);
	localparam int CNT_W     = 7;
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	// Blend fraction runs from 0 up to and including 1.0
	localparam int FRAC_W    = FRAC_BITS + 1;
	localparam int NCOMP     = 3;
	localparam int MOD_STEPS = DATA_W;
	localparam int DIV_STEPS = FRAC_W;
	localparam int STEP_W    = $clog2(MOD_STEPS);
	localparam int PADDR_W   = 3;

	typedef enum logic {
		ACT_WRITE  = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef enum logic {
		REG_KEY_COUNT     = 1'b0,
		REG_ANIM_DURATION = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               action;
		logic [5:0]         key_index;
		logic [31:0]        key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0]        sample_time;
	} req_t;

	typedef struct packed {
		logic [31:0]        wrapped_time;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
	} rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0]            key_time;
		logic [NCOMP-1:0][DATA_W-1:0] val;
	} key_entry_t;

	typedef enum logic [1:0] {
		ADDR_FIRST = 2'd0,
		ADDR_NEXT  = 2'd1,
		ADDR_A     = 2'd2,
		ADDR_B     = 2'd3
	} addr_sel_t;

	typedef struct packed {
		logic      wr;
		logic      load;
		logic      mod_step;
		logic      chk_first;
		logic      scan_step;
		logic      div_step;
		logic      lat_a;
		logic      lat_b;
		logic      mul;
		logic      out_load;
		addr_sel_t addr_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic dur_zero;
		logic mod_last;
		logic div_last;
		logic first_hit;
		logic seg_hit;
		logic seg_last;
		logic span_zero;
	} dp_sts_t;

endpackage

/* design/keyframe_vector_lerp_sampler.sv */
// Keyframe vector lerp sampler top: APB registers, kvls_ctrl and kvls_dp (kvls_pkg).
// A sample request runs a serial modulo of its time by anim_duration (skipped when
// anim_duration is zero), scans the key table for its segment (one key per table read),
// runs a serial divide for the blend fraction (skipped for a zero-length segment), then blends.
// No new request is taken while a sample is in progress, until its result is loaded for output.
// Reset clears control and sets key_count to 1, anim_duration to 0; the key table is not cleared.
`timescale 1ns / 1ps

module keyframe_vector_lerp_sampler import kvls_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req_data,
	// result channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp_data,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	logic [CNT_W-1:0]  key_count_q;
	logic [DATA_W-1:0] anim_duration_q;
	logic              cfg_wr;
	reg_idx_t          reg_idx;
	dp_cmd_t           cmd;
	dp_sts_t           sts;

	// Registers sit one word apart; bit 2 of the address picks the register
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Take configuration writes in the access phase; the port never waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q     <= CNT_W'(1);
			anim_duration_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_KEY_COUNT:     key_count_q <= pwdata[CNT_W-1:0];
				REG_ANIM_DURATION: anim_duration_q <= pwdata;
				default:           key_count_q <= key_count_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KEY_COUNT:     prdata = DATA_W'(key_count_q);
			REG_ANIM_DURATION: prdata = anim_duration_q;
			default:           prdata = '0;
		endcase
	end

	// Sequence each request: wrap, scan segments, divide, blend, then hold the
	// result until the consumer drops stall
	kvls_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req_data.action),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Key table, shared divider and the three blend lanes
	kvls_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_data      (req_data),
		.key_count     (key_count_q),
		.anim_duration (anim_duration_q),
		.rsp_data      (rsp_data)
	);

endmodule

/* design/kvls_dp.sv */
// Datapath: key table memory, shared serial divider, segment scan, blend lanes.
// Depends on kvls_pkg; driven by commands from kvls_ctrl.
`timescale 1ns / 1ps

module kvls_dp import kvls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  req_t              req_data,
	input  logic [CNT_W-1:0]  key_count,
	input  logic [DATA_W-1:0] anim_duration,
	output rsp_t              rsp_data
);

	key_entry_t mem_q [MAX_KEYS];
	key_entry_t rd_q;
	key_entry_t wr_entry;
	logic       wr_ok;

	logic [KEY_AW-1:0] rd_addr;
	logic [KEY_AW-1:0] idx_q;
	logic [KEY_AW-1:0] sel_a_q;
	logic [KEY_AW-1:0] sel_b_q;
	logic [KEY_AW-1:0] n_last;

	logic [DATA_W-1:0] tm_q;
	logic [DATA_W-1:0] num_q;
	logic [DATA_W-1:0] t_prev_q;
	logic [DATA_W-1:0] span_q;
	logic [DATA_W:0]   rem_q;
	logic [FRAC_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;

	logic [DATA_W:0] div_a;
	logic [DATA_W:0] div_d;
	logic [DATA_W:0] div_diff;
	logic [DATA_W:0] div_res;
	logic            div_ge;

	logic signed [DATA_W-1:0]        va_q   [NCOMP];
	logic signed [DATA_W:0]          diff_q [NCOMP];
	logic signed [DATA_W+FRAC_W+1:0] prod_q [NCOMP];
	logic signed [FRAC_W:0]          frac_s;

	rsp_t rsp_q;

	// Last key in use: a count of zero acts as one, a count above the table as full
	always_comb begin
		if (key_count == '0) begin
			n_last = '0;
		end else if (int'(key_count) > MAX_KEYS) begin
			n_last = KEY_AW'(MAX_KEYS - 1);
		end else begin
			n_last = KEY_AW'(key_count - 1'b1);
		end
	end

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_FIRST: rd_addr = '0;
			ADDR_NEXT:  rd_addr = idx_q + 1'b1;
			ADDR_A:     rd_addr = sel_a_q;
			ADDR_B:     rd_addr = sel_b_q;
			default:    rd_addr = '0;
		endcase
	end

	always_comb begin
		wr_entry.key_time = req_data.key_time;
		wr_entry.val[0]   = req_data.key_x;
		wr_entry.val[1]   = req_data.key_y;
		wr_entry.val[2]   = req_data.key_z;
		wr_ok             = int'(req_data.key_index) < MAX_KEYS;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_ok) begin
			mem_q[KEY_AW'(req_data.key_index)] <= wr_entry;
		end
		rd_q <= mem_q[rd_addr];
	end

	// One compare-subtract shared by the wrap modulo and the fraction divide
	always_comb begin
		if (cmd.div_step) begin
			div_a = rem_q;
			div_d = {1'b0, span_q};
		end else begin
			div_a = {rem_q[DATA_W-1:0], num_q[DATA_W-1]};
			div_d = {1'b0, anim_duration};
		end
		div_ge   = div_a >= div_d;
		div_diff = div_a - div_d;
		div_res  = div_ge ? div_diff : div_a;
	end

	always_comb begin
		sts.dur_zero  = anim_duration == '0;
		sts.mod_last  = step_q == STEP_W'(MOD_STEPS - 1);
		sts.div_last  = step_q == STEP_W'(DIV_STEPS - 1);
		sts.first_hit = (n_last == '0) || (tm_q <= rd_q.key_time);
		sts.seg_hit   = (t_prev_q <= tm_q) && (tm_q <= rd_q.key_time);
		sts.seg_last  = idx_q == n_last;
		sts.span_zero = rd_q.key_time == t_prev_q;
	end

	assign frac_s = $signed({1'b0, quot_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			step_q <= '0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				step_q <= '0;
			end
			if (cmd.mod_step || cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.chk_first) begin
				idx_q <= KEY_AW'(1);
			end
			if (cmd.scan_step) begin
				if (sts.seg_hit) begin
					step_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tm_q   <= req_data.sample_time;
			num_q  <= req_data.sample_time;
			rem_q  <= '0;
			quot_q <= '0;
		end
		if (cmd.mod_step) begin
			rem_q <= div_res;
			num_q <= {num_q[DATA_W-2:0], 1'b0};
			if (sts.mod_last) begin
				tm_q <= div_res[DATA_W-1:0];
			end
		end
		if (cmd.chk_first) begin
			if (sts.first_hit) begin
				sel_a_q <= '0;
				sel_b_q <= '0;
			end else begin
				t_prev_q <= rd_q.key_time;
			end
		end
		if (cmd.scan_step) begin
			if (sts.seg_hit) begin
				sel_a_q <= idx_q - 1'b1;
				sel_b_q <= idx_q;
				rem_q   <= {1'b0, tm_q - t_prev_q};
				span_q  <= rd_q.key_time - t_prev_q;
			end else begin
				t_prev_q <= rd_q.key_time;
				if (sts.seg_last) begin
					sel_a_q <= n_last;
					sel_b_q <= n_last;
				end
			end
		end
		if (cmd.div_step) begin
			rem_q  <= {div_res[DATA_W-1:0], 1'b0};
			quot_q <= {quot_q[FRAC_W-2:0], div_ge};
		end
		for (int c = 0; c < NCOMP; c++) begin
			if (cmd.lat_a) begin
				va_q[c] <= rd_q.val[c];
			end
			if (cmd.lat_b) begin
				diff_q[c] <= $signed({rd_q.val[c][DATA_W-1], rd_q.val[c]})
					- $signed({va_q[c][DATA_W-1], va_q[c]});
			end
			if (cmd.mul) begin
				prod_q[c] <= diff_q[c] * frac_s;
			end
		end
		if (cmd.out_load) begin
			rsp_q.wrapped_time <= tm_q;
			rsp_q.value_x <= va_q[0] + prod_q[0][DATA_W+FRAC_BITS-1:FRAC_BITS];
			rsp_q.value_y <= va_q[1] + prod_q[1][DATA_W+FRAC_BITS-1:FRAC_BITS];
			rsp_q.value_z <= va_q[2] + prod_q[2][DATA_W+FRAC_BITS-1:FRAC_BITS];
		end
	end

	assign rsp_data = rsp_q;

`ifndef NO_ASSERTIONS
	// Fraction never exceeds 1.0 since the sample lies inside its segment
	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> !(quot_q[FRAC_W-1] && (quot_q[FRAC_W-2:0] != '0)))
		else $error("blend fraction above one");
`endif

endmodule

/* design/kvls_ctrl.sv */
// Controller state machine: request handshake, sequencing, result register valid.
// Depends on kvls_pkg; commands kvls_dp and reads its status.
`timescale 1ns / 1ps

module kvls_ctrl import kvls_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  logic    req_action,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		IDLE,
		MOD,
		RD0,
		CHK0,
		SCAN,
		DIV,
		FETA,
		RDA,
		RDB,
		MUL,
		FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   req_acc;

	assign req_stall = state_q != IDLE;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				cmd.wr   = req_acc && (req_action == ACT_WRITE);
				cmd.load = req_acc && (req_action == ACT_SAMPLE);
			end
			MOD:  cmd.mod_step = 1'b1;
			RD0:  cmd.addr_sel = ADDR_FIRST;
			CHK0: begin
				cmd.chk_first = 1'b1;
				cmd.addr_sel  = ADDR_NEXT;
			end
			SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.addr_sel  = ADDR_NEXT;
			end
			DIV:  cmd.div_step = 1'b1;
			FETA: cmd.addr_sel = ADDR_A;
			RDA: begin
				cmd.lat_a    = 1'b1;
				cmd.addr_sel = ADDR_B;
			end
			RDB:  cmd.lat_b = 1'b1;
			MUL:  cmd.mul = 1'b1;
			FIN:  cmd.out_load = !rsp_valid_q || !rsp_stall;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (cmd.load) begin
						state_q <= sts.dur_zero ? RD0 : MOD;
					end
				end
				MOD: begin
					if (sts.mod_last) begin
						state_q <= RD0;
					end
				end
				RD0:  state_q <= CHK0;
				CHK0: state_q <= sts.first_hit ? FETA : SCAN;
				SCAN: begin
					if (sts.seg_hit) begin
						state_q <= sts.span_zero ? FETA : DIV;
					end else if (sts.seg_last) begin
						state_q <= FETA;
					end
				end
				DIV: begin
					if (sts.div_last) begin
						state_q <= FETA;
					end
				end
				FETA: state_q <= RDA;
				RDA:  state_q <= RDB;
				RDB:  state_q <= MUL;
				MUL:  state_q <= FIN;
				FIN: begin
					if (cmd.out_load) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == FIN))
		else $error("result raised outside the finish state");
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == MOD) || (state_q == RD0))
		else $error("sample request did not start the wrap or scan");
	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> state_q == IDLE)
		else $error("key write left the idle state");
`endif

endmodule
